@@ hw/rtl/dheap_pkg.sv @@
// Package for the d-ary min-heap unit: sizes, codes and the sequencer state type.
// No dependencies.
package dheap_pkg;

    localparam int unsigned CAPACITY_DEF = 1024;
    localparam int unsigned ARITY_DEF    = 4;
    localparam int unsigned KEY_W        = 32;
    localparam int unsigned HANDLE_W     = 10;
    localparam int unsigned COUNT_W      = 11;
    localparam int unsigned STATUS_W     = 2;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_RD,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD,
        S_POP_LAST,
        S_DN_RD,
        S_DN_CMP,
        S_TOP_RD,
        S_TOP_WAIT,
        S_OUT
    } seq_state_t;

endpackage

@@ hw/rtl/dheap_store.sv @@
// Heap entry store: one synchronous memory of key/handle pairs.
// Depends on dheap_pkg.
module dheap_store #(
    parameter int unsigned CAPACITY = dheap_pkg::CAPACITY_DEF,
    parameter int unsigned AW       = $clog2(CAPACITY),
    parameter int unsigned HW       = $clog2(CAPACITY)
) (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [dheap_pkg::KEY_W-1:0]    wkey,
    input  logic [HW-1:0]                  whandle,
    input  logic [AW-1:0]                  raddr,
    output logic [dheap_pkg::KEY_W-1:0]    rkey,
    output logic [HW-1:0]                  rhandle
);

    logic [dheap_pkg::KEY_W+HW-1:0] mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= {whandle, wkey};
        end
        {rhandle, rkey} <= mem[raddr];
    end

endmodule

@@ hw/rtl/dary_min_heap_with_slot_handles_unit.sv @@
// D-ary min-heap with slot handles: one beat in, one beat out per operation.
// Clear, mode 3 and flagged beats go straight to the top read; a push sifts the new entry
// up toward the root; a pop moves the last entry to the root and sifts it down, reading
// the children of each level that it visits.
// One operation at a time: the next input beat is taken the cycle after the result
// beat leaves. Sift reads a single-port-read entry memory one child per cycle.
// Synchronous active-low reset clears counts, free-list depth and handle counter.
module dary_min_heap_with_slot_handles_unit #(
    parameter int unsigned CAPACITY = dheap_pkg::CAPACITY_DEF,
    parameter int unsigned ARITY    = dheap_pkg::ARITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[1:0], key[33:2], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    // handle[9:0], top_key[41:10], top_handle[51:42], count[62:52], status[64:63],
    // zero fill
    output logic [71:0] m_tdata
);

    localparam int unsigned AW  = $clog2(CAPACITY);
    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    localparam int unsigned HW  = (AW > 0) ? AW : 1;
    localparam int unsigned JW  = $clog2(ARITY + 1);
    localparam int unsigned KW  = dheap_pkg::KEY_W;
    localparam int unsigned OHW = dheap_pkg::HANDLE_W;
    // parent index by reciprocal multiply, exact over the whole index range
    localparam int unsigned DSH = CW + $clog2(ARITY);
    localparam longint unsigned DMUL = ((64'd1 << DSH) + 64'(ARITY) - 64'd1) / 64'(ARITY);

    // ---------------- registers
    dheap_pkg::seq_state_t state_reg, state_next;
    logic signed [KW-1:0] key_reg, key_next;     // moving key
    logic [HW-1:0]     hnd_reg, hnd_next;        // moving handle
    logic [CW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     fdep_reg, fdep_next;
    logic [CW-1:0]     nxt_reg, nxt_next;
    logic [HW-1:0]     out_h_reg, out_h_next;
    logic [1:0]        stat_reg, stat_next;
    logic signed [KW-1:0] best_k_reg, best_k_next;
    logic [HW-1:0]     best_h_reg, best_h_next;
    logic [CW-1:0]     best_p_reg, best_p_next;
    logic [JW-1:0]     j_reg, j_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [CW-1:0]     rd_pos_reg, rd_pos_next;
    logic [OHW-1:0]    top_h_reg, top_h_next;
    logic signed [KW-1:0] top_k_reg, top_k_next;

    // ---------------- memories
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [KW-1:0] wkey, rkey;
    logic [HW-1:0] whnd, rhnd;

    dheap_store #(.CAPACITY(CAPACITY), .AW(AW), .HW(HW)) u_store (
        .aclk(aclk), .we(we), .waddr(waddr), .wkey(wkey), .whandle(whnd),
        .raddr(raddr), .rkey(rkey), .rhandle(rhnd)
    );

    logic [HW-1:0] free_mem [CAPACITY];
    logic          fwe;
    logic [AW-1:0] fwaddr, fraddr;
    logic [HW-1:0] fwdata, frdata;

    always_ff @(posedge aclk) begin
        if (fwe) begin
            free_mem[fwaddr] <= fwdata;
        end
        frdata <= free_mem[fraddr];
    end

    // ---------------- helpers
    logic [CW-1:0] parent_pos;
    logic [CW+DSH-1:0] par_prod;
    logic [CW+4:0] child_wide;
    assign par_prod   = (CW+DSH)'(pos_reg - CW'(1)) * (CW+DSH)'(DMUL);
    assign parent_pos = CW'(par_prod >> DSH);
    assign child_wide = (CW+5)'(pos_reg) * (CW+5)'(ARITY) + (CW+5)'(1);

    logic [CW+4:0] rd_next_wide;
    assign rd_next_wide = (CW+5)'(rd_pos_reg) + (CW+5)'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dheap_pkg::S_IDLE;
            cnt_reg   <= '0;
            fdep_reg  <= '0;
            nxt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fdep_reg  <= fdep_next;
            nxt_reg   <= nxt_next;
        end
        key_reg     <= key_next;
        hnd_reg     <= hnd_next;
        pos_reg     <= pos_next;
        out_h_reg   <= out_h_next;
        stat_reg    <= stat_next;
        best_k_reg  <= best_k_next;
        best_h_reg  <= best_h_next;
        best_p_reg  <= best_p_next;
        j_reg       <= j_next;
        rd_pend_reg <= rd_pend_next;
        rd_pos_reg  <= rd_pos_next;
        top_h_reg   <= top_h_next;
        top_k_reg   <= top_k_next;
    end

    always_comb begin
        state_next   = state_reg;
        key_next     = key_reg;
        hnd_next     = hnd_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        fdep_next    = fdep_reg;
        nxt_next     = nxt_reg;
        out_h_next   = out_h_reg;
        stat_next    = stat_reg;
        best_k_next  = best_k_reg;
        best_h_next  = best_h_reg;
        best_p_next  = best_p_reg;
        j_next       = j_reg;
        rd_pend_next = 1'b0;
        rd_pos_next  = rd_pos_reg;
        top_h_next   = top_h_reg;
        top_k_next   = top_k_reg;
        we     = 1'b0;
        waddr  = AW'(pos_reg);
        wkey   = key_reg;
        whnd   = hnd_reg;
        raddr  = '0;
        fwe    = 1'b0;
        fwaddr = AW'(fdep_reg);
        fwdata = rhnd;
        fraddr = AW'(fdep_reg - CW'(1));
        s_tready = 1'b0;
        m_tvalid = 1'b0;

        case (state_reg)
            dheap_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    key_next   = s_tdata[33:2];
                    out_h_next = '0;
                    stat_next  = dheap_pkg::ST_OK;
                    case (s_tdata[1:0])
                        dheap_pkg::MODE_PUSH: begin
                            if (cnt_reg >= CW'(CAPACITY) ||
                                (fdep_reg == '0 && nxt_reg >= CW'(CAPACITY))) begin
                                stat_next  = dheap_pkg::ST_FULL;
                                state_next = dheap_pkg::S_TOP_RD;
                            end else begin
                                state_next = dheap_pkg::S_PUSH_RD;
                            end
                        end
                        dheap_pkg::MODE_POP: begin
                            if (cnt_reg == '0) begin
                                stat_next  = dheap_pkg::ST_EMPTY;
                                state_next = dheap_pkg::S_TOP_RD;
                            end else begin
                                state_next = dheap_pkg::S_POP_RD;
                            end
                        end
                        dheap_pkg::MODE_CLEAR: begin
                            cnt_next   = '0;
                            fdep_next  = '0;
                            nxt_next   = '0;
                            state_next = dheap_pkg::S_TOP_RD;
                        end
                        default: state_next = dheap_pkg::S_TOP_RD;
                    endcase
                end
            end
            // free-list read issued this cycle when stack not empty
            dheap_pkg::S_PUSH_RD: begin
                pos_next = cnt_reg;
                cnt_next = cnt_reg + CW'(1);
                if (fdep_reg != '0) begin
                    fdep_next    = fdep_reg - CW'(1);
                    rd_pend_next = 1'b1;
                end else begin
                    hnd_next   = HW'(nxt_reg);
                    out_h_next = HW'(nxt_reg);
                    nxt_next   = nxt_reg + CW'(1);
                end
                state_next = dheap_pkg::S_UP_RD;
            end
            // sift up: read parent
            dheap_pkg::S_UP_RD: begin
                if (rd_pend_reg) begin
                    hnd_next   = frdata;
                    out_h_next = frdata;
                end
                if (pos_reg == '0) begin
                    we         = 1'b1;
                    whnd       = rd_pend_reg ? frdata : hnd_reg;
                    state_next = dheap_pkg::S_TOP_RD;
                end else begin
                    raddr      = AW'(parent_pos);
                    state_next = dheap_pkg::S_UP_CMP;
                end
            end
            dheap_pkg::S_UP_CMP: begin
                if (key_reg < $signed(rkey)) begin
                    we         = 1'b1;
                    wkey       = rkey;
                    whnd       = rhnd;
                    pos_next   = parent_pos;
                    state_next = dheap_pkg::S_UP_RD;
                end else begin
                    we         = 1'b1;
                    state_next = dheap_pkg::S_TOP_RD;
                end
            end
            // pop: read root handle
            dheap_pkg::S_POP_RD: begin
                raddr      = '0;
                cnt_next   = cnt_reg - CW'(1);
                state_next = dheap_pkg::S_POP_LAST;
            end
            dheap_pkg::S_POP_LAST: begin
                // rhnd holds root handle; read last entry next
                out_h_next = rhnd;
                if (fdep_reg < CW'(CAPACITY)) begin
                    fwe       = 1'b1;
                    fdep_next = fdep_reg + CW'(1);
                end
                raddr    = AW'(cnt_reg);
                pos_next = '0;
                if (cnt_reg == '0) begin
                    state_next = dheap_pkg::S_TOP_RD;
                end else begin
                    state_next = dheap_pkg::S_DN_RD;
                    j_next     = '0;
                    rd_pend_next = 1'b1;
                end
            end
            // sift down: rd_pend marks the first beat, latching moving entry
            dheap_pkg::S_DN_RD: begin
                if (rd_pend_reg) begin
                    key_next = rkey;
                    hnd_next = rhnd;
                end
                if (child_wide >= (CW+5)'(cnt_reg)) begin
                    we         = 1'b1;
                    wkey       = rd_pend_reg ? rkey : key_reg;
                    whnd       = rd_pend_reg ? rhnd : hnd_reg;
                    state_next = dheap_pkg::S_TOP_RD;
                end else begin
                    raddr       = AW'(child_wide);
                    rd_pos_next = CW'(child_wide);
                    best_p_next = CW'(child_wide);
                    j_next      = '0;
                    state_next  = dheap_pkg::S_DN_CMP;
                end
            end
            // one child arrives per cycle; next child read in parallel
            dheap_pkg::S_DN_CMP: begin
                if (j_reg == '0 || $signed(rkey) < best_k_reg) begin
                    best_k_next = rkey;
                    best_h_next = rhnd;
                    best_p_next = rd_pos_reg;
                end
                if (JW'(j_reg + JW'(1)) < JW'(ARITY) &&
                    rd_next_wide < (CW+5)'(cnt_reg)) begin
                    raddr       = AW'(rd_next_wide);
                    rd_pos_next = CW'(rd_next_wide);
                    j_next      = j_reg + JW'(1);
                end else begin
                    logic signed [KW-1:0] bk;
                    logic [HW-1:0]        bh;
                    logic [CW-1:0]        bp;
                    bk = best_k_reg;
                    bh = best_h_reg;
                    bp = best_p_reg;
                    if (j_reg == '0 || $signed(rkey) < best_k_reg) begin
                        bk = rkey;
                        bh = rhnd;
                        bp = rd_pos_reg;
                    end
                    we = 1'b1;
                    if (bk < key_reg) begin
                        wkey       = bk;
                        whnd       = bh;
                        pos_next   = bp;
                        state_next = dheap_pkg::S_DN_RD;
                    end else begin
                        state_next = dheap_pkg::S_TOP_RD;
                    end
                end
            end
            dheap_pkg::S_TOP_RD: begin
                raddr      = '0;
                state_next = dheap_pkg::S_TOP_WAIT;
            end
            dheap_pkg::S_TOP_WAIT: begin
                top_k_next = (cnt_reg != '0) ? $signed(rkey) : '0;
                top_h_next = (cnt_reg != '0) ? OHW'(rhnd) : '0;
                state_next = dheap_pkg::S_OUT;
            end
            dheap_pkg::S_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = dheap_pkg::S_IDLE;
                end
            end
            default: state_next = dheap_pkg::S_IDLE;
        endcase
    end

    assign m_tdata = {7'd0, stat_reg, dheap_pkg::COUNT_W'(cnt_reg), top_h_reg,
                      top_k_reg, OHW'(out_h_reg)};

endmodule

@@ test/tb_top.sv @@
// Testbench for the d-ary min-heap unit: directed and random push/pop/clear beats,
// checked against an in-bench heap predictor. Depends on dheap_pkg and the unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 1024;
    localparam int ARY = 4;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] count;
        logic [9:0]  top_handle;
        logic [31:0] top_key;
        logic [9:0]  handle;
    } heap_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    dary_min_heap_with_slot_handles_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    logic signed [31:0] pk_key [CAP];
    logic [9:0]         pk_hdl [CAP];
    logic [9:0]         free_lifo [CAP];
    int                 free_top, hdl_ctr, held;
    heap_res_t          expected_q[$];
    int                 errors = 0;
    bit                 stall_long = 1'b0;
    bit                 rand_idle = 1'b1;

    task automatic sift_up(input int pos);
        logic signed [31:0] k;
        logic [9:0] h;
        int up;
        k = pk_key[pos];
        h = pk_hdl[pos];
        while (pos > 0) begin
            up = (pos - 1) / ARY;
            if (k >= pk_key[up]) break;
            pk_key[pos] = pk_key[up];
            pk_hdl[pos] = pk_hdl[up];
            pos = up;
        end
        pk_key[pos] = k;
        pk_hdl[pos] = h;
    endtask

    task automatic root_settle();
        logic signed [31:0] k;
        logic [9:0] h;
        int pos, first, last, best;
        pos = 0;
        k = pk_key[0];
        h = pk_hdl[0];
        forever begin
            first = pos * ARY + 1;
            if (first >= held) break;
            last = (first + ARY > held) ? held : first + ARY;
            best = first;
            for (int j = first + 1; j < last; j++)
                if (pk_key[j] < pk_key[best]) best = j;
            if (pk_key[best] >= k) break;
            pk_key[pos] = pk_key[best];
            pk_hdl[pos] = pk_hdl[best];
            pos = best;
        end
        pk_key[pos] = k;
        pk_hdl[pos] = h;
    endtask

    task automatic predict_heap_op(input logic [1:0] mode, input logic signed [31:0] key);
        heap_res_t r;
        r = '0;
        if (mode == dheap_pkg::MODE_PUSH) begin
            if (held >= CAP || (free_top == 0 && hdl_ctr >= CAP)) begin
                r.status = dheap_pkg::ST_FULL;
            end else begin
                if (free_top > 0) begin
                    free_top--;
                    r.handle = free_lifo[free_top];
                end else begin
                    r.handle = hdl_ctr[9:0];
                    hdl_ctr++;
                end
                pk_key[held] = key;
                pk_hdl[held] = r.handle;
                held++;
                sift_up(held - 1);
            end
        end else if (mode == dheap_pkg::MODE_POP) begin
            if (held == 0) begin
                r.status = dheap_pkg::ST_EMPTY;
            end else begin
                r.handle = pk_hdl[0];
                held--;
                if (held > 0) begin
                    pk_key[0] = pk_key[held];
                    pk_hdl[0] = pk_hdl[held];
                end
                if (free_top < CAP) begin
                    free_lifo[free_top] = r.handle;
                    free_top++;
                end
                if (held > 1) root_settle();
            end
        end else if (mode == dheap_pkg::MODE_CLEAR) begin
            held = 0;
            free_top = 0;
            hdl_ctr = 0;
        end
        if (held > 0) begin
            r.top_key = pk_key[0];
            r.top_handle = pk_hdl[0];
        end
        r.count = held[10:0];
        expected_q.insert(expected_q.size(), r);
    endtask

    // send one beat, after a random gap when rand_idle is set; predict on acceptance
    task automatic send_op(input logic [1:0] mode, input logic [31:0] key);
        int gap;
        gap = rand_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, key, mode};
        do @(posedge aclk); while (!s_tready);
        predict_heap_op(mode, key);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // receiver: random, long or no stalls
    initial begin
        int wait_n;
        @(posedge aresetn);
        forever begin
            if (stall_long) wait_n = 300;
            else wait_n = rand_idle ? $urandom_range(0, 13) : 0;
            if (wait_n > 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // result checker
    always @(posedge aclk) begin
        heap_res_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[64:0];
            if (expected_q.size() == 0) begin
                $error("unexpected result beat %h", m_tdata);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got.handle !== exp_r.handle) begin
                    $error("handle exp %0d got %0d", exp_r.handle, got.handle); errors++;
                end
                if (got.top_key !== exp_r.top_key) begin
                    $error("top_key exp %0d got %0d", $signed(exp_r.top_key),
                           $signed(got.top_key)); errors++;
                end
                if (got.top_handle !== exp_r.top_handle) begin
                    $error("top_handle exp %0d got %0d", exp_r.top_handle,
                           got.top_handle); errors++;
                end
                if (got.count !== exp_r.count) begin
                    $error("count exp %0d got %0d", exp_r.count, got.count); errors++;
                end
                if (got.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_op(dheap_pkg::MODE_POP, 32'd0);            // pop on empty
        send_op(dheap_pkg::MODE_PUSH, 32'h7FFF_FFFF);
        send_op(dheap_pkg::MODE_PUSH, 32'h8000_0000);
        send_op(dheap_pkg::MODE_PUSH, 32'hFFFF_FFFF);
        send_op(dheap_pkg::MODE_PUSH, 32'd0);
        send_op(dheap_pkg::MODE_PUSH, 32'h5555_5555);
        send_op(dheap_pkg::MODE_PUSH, 32'hAAAA_AAAA);
        send_op(dheap_pkg::MODE_PUSH, 32'd0);           // duplicate key
        send_op(dheap_pkg::MODE_NOP, 32'h1234_5678);    // unused mode
        send_op(dheap_pkg::MODE_POP, 32'hFFFF_FFFF);
        send_op(dheap_pkg::MODE_POP, 32'd0);
        send_op(dheap_pkg::MODE_PUSH, 32'd7);           // reuses freed handle
        send_op(dheap_pkg::MODE_CLEAR, 32'd0);
        send_op(dheap_pkg::MODE_POP, 32'd0);
        send_op(dheap_pkg::MODE_PUSH, 32'd1);
    endtask

    // fill to capacity, push on full, pop 20, push 20 more, push on full again, then clear
    task automatic test_full_heap();
        rand_idle = 1'b0;
        for (int i = 0; i < CAP; i++) send_op(dheap_pkg::MODE_PUSH, $urandom());
        send_op(dheap_pkg::MODE_PUSH, 32'd5);
        for (int i = 0; i < 20; i++) send_op(dheap_pkg::MODE_POP, 32'd0);
        for (int i = 0; i < 20; i++) send_op(dheap_pkg::MODE_PUSH, $urandom_range(0, 50));
        send_op(dheap_pkg::MODE_PUSH, 32'd9);
        send_op(dheap_pkg::MODE_CLEAR, 32'd0);
        rand_idle = 1'b1;
    endtask

    task automatic test_back_pressure();
        stall_long = 1'b1;
        for (int i = 0; i < 6; i++) send_op(dheap_pkg::MODE_PUSH, $urandom());
        stall_long = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int sel;
        for (int i = 0; i < 180; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                send_op(dheap_pkg::MODE_PUSH,
                        (sel < 20) ? $urandom_range(0, 15) : $urandom());
            end
            else if (sel < 97) send_op(dheap_pkg::MODE_POP, $urandom());
            else if (sel < 99) send_op(dheap_pkg::MODE_CLEAR, $urandom());
            else send_op(dheap_pkg::MODE_NOP, $urandom());
            if (i == 90) wait_drained();
        end
    endtask

    initial begin
        free_top = 0;
        hdl_ctr = 0;
        held = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_back_pressure();
        test_random();
        test_full_heap();
        wait_drained();
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0)
            $display("dary_min_heap_with_slot_handles_unit regression: pass");
        else
            $display("dary_min_heap_with_slot_handles_unit regression: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("dary_min_heap_with_slot_handles_unit regression: fail");
        $finish;
    end
endmodule
